// ===== hw/rtl/rsi_tt_pkg.sv =====
// Shared types and constants of the RSI threshold trader.
package rsi_tt_pkg;

  localparam int unsigned CfgW  = 7;
  localparam int unsigned HoldW = 8;
  localparam int unsigned CashW = 48;

  // RSI percent scale: 100 * gains is compared against level * (gains + losses)
  localparam logic [CfgW-1:0] RsiScale = 7'd100;

  localparam logic [CfgW-1:0] WindowRst     = 7'd14;
  localparam logic [CfgW-1:0] OversoldRst   = 7'd30;
  localparam logic [CfgW-1:0] OverboughtRst = 7'd70;
  localparam logic [CfgW-1:0] LimitRst      = 7'd3;

  typedef enum logic [1:0] {
    ACT_HOLD = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_WINDOW     = 2'd0,
    REG_OVERSOLD   = 2'd1,
    REG_OVERBOUGHT = 2'd2,
    REG_LIMIT      = 2'd3
  } cfg_reg_e;

  // Item leaving the window stage toward the decision stages
  typedef struct packed {
    logic valid;
    logic ready_res;
  } item_t;

endpackage

// ===== hw/rtl/rsi_tt_cell.sv =====
// One cell of the difference delay line: holds one price difference.
module rsi_tt_cell #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned IDX_W  = 6,
  parameter int unsigned DIFF_W = 33
) (
  input  logic                     clk_i,
  input  logic                     shift_i,
  input  logic [IDX_W-1:0]         tail_idx_i,
  input  logic signed [DIFF_W-1:0] new_diff_i,
  input  logic signed [DIFF_W-1:0] next_diff_i,
  output logic signed [DIFF_W-1:0] diff_o
);

  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic                     is_tail;

  assign is_tail = (tail_idx_i == IDX_W'(IDX));

  // The tail cell takes the fresh difference, the others take their upper neighbor
  always_comb begin
    if (is_tail) begin
      diff_d = new_diff_i;
    end else begin
      diff_d = next_diff_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      diff_q <= diff_d;
    end
  end

  assign diff_o = diff_q;

endmodule

// ===== hw/rtl/rsi_tt_chain.sv =====
// Variable-length delay line of price differences built from a row of cells.
module rsi_tt_chain #(
  parameter int unsigned MAX_WINDOW = 64,
  parameter int unsigned DIFF_W     = 33
) (
  input  logic                             clk_i,
  input  logic                             shift_i,
  input  logic [$clog2(MAX_WINDOW)-1:0]    tail_idx_i,
  input  logic signed [DIFF_W-1:0]         new_diff_i,
  output logic signed [DIFF_W-1:0]         oldest_o
);

  localparam int unsigned IdxW = $clog2(MAX_WINDOW);

  logic signed [DIFF_W-1:0] diff [MAX_WINDOW];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [DIFF_W-1:0] next_diff;

    if (i == MAX_WINDOW - 1) begin : g_top
      assign next_diff = new_diff_i;
    end else begin : g_mid
      assign next_diff = diff[i+1];
    end

    rsi_tt_cell #(
      .IDX    (i),
      .IDX_W  (IdxW),
      .DIFF_W (DIFF_W)
    ) u_cell (
      .clk_i       (clk_i),
      .shift_i     (shift_i),
      .tail_idx_i  (tail_idx_i),
      .new_diff_i  (new_diff_i),
      .next_diff_i (next_diff),
      .diff_o      (diff[i])
    );
  end

  // A difference entered at the tail reaches cell 0 after n-1 shifts
  assign oldest_o = diff[0];

endmodule

// ===== hw/rtl/rsi_tt_decide.sv =====
// Product and decision stages: RSI compare, position and cash update, output register.
module rsi_tt_decide import rsi_tt_pkg::*; #(
  parameter int unsigned PRICE_BITS = 32,
  parameter int unsigned SUM_W      = 38
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  item_t                 item_i,
  input  logic [PRICE_BITS-1:0] price_i,
  input  logic [SUM_W-1:0]      gain_i,
  input  logic [SUM_W-1:0]      loss_i,
  input  logic [CfgW-1:0]       oversold_i,
  input  logic [CfgW-1:0]       overbought_i,
  input  logic [CfgW-1:0]       limit_i,
  output logic                  take_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // holding[7:0], cash[55:8], report_order[56], zero fill [63:57]
  output logic [63:0]           m_axis_tdata_o,
  // ready_res[0], action[2:1]
  output logic [2:0]            m_axis_tuser_o
);

  localparam int unsigned TotW = SUM_W + 1;
  localparam int unsigned ProdW = TotW + CfgW;
  localparam int unsigned ExtW = CashW + 2;

  // ---- product stage ----
  logic                  v2_q, v2_d;
  logic                  rdy2_q, nz2_q;
  logic [PRICE_BITS-1:0] price2_q;
  logic [ProdW-1:0]      pg_q, pos_q, pob_q;
  logic [TotW-1:0]       total;
  logic                  load2, mv23, s2_free;

  // ---- decision stage ----
  logic                    v3_q, v3_d;
  logic                    rdy3_q, rep_q, rep_d;
  action_e                 act_q, act_d, dir_q;
  logic signed [HoldW-1:0] hold_q, hold_d;
  logic signed [CashW-1:0] cash_q, cash_d;
  logic signed [HoldW:0]   hold_x, lim_x;
  logic [ExtW-1:0]         cash_x, price_x, cash_sub, cash_add;
  logic [CashW-1:0]        sub_sat, add_sat;
  logic                    buy, sell;

  assign mv23    = v2_q && (!v3_q || m_axis_tready_i);
  assign s2_free = !v2_q || mv23;
  assign load2   = item_i.valid && s2_free;
  assign take_o  = s2_free;

  assign total = TotW'(gain_i) + TotW'(loss_i);

  always_comb begin
    v2_d = v2_q;
    if (load2) begin
      v2_d = 1'b1;
    end else if (mv23) begin
      v2_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load2) begin
      rdy2_q   <= item_i.ready_res;
      nz2_q    <= (total != '0);
      price2_q <= price_i;
      pg_q     <= ProdW'(gain_i) * ProdW'(RsiScale);
      pos_q    <= ProdW'(total) * ProdW'(oversold_i);
      pob_q    <= ProdW'(total) * ProdW'(overbought_i);
    end
  end

  // Position limits compared in one extra bit so that -limit fits
  assign hold_x = {hold_q[HoldW-1], hold_q};
  assign lim_x  = $signed({2'b00, limit_i});

  assign buy  = rdy2_q && nz2_q && (pg_q < pos_q) && (hold_x < lim_x);
  assign sell = rdy2_q && nz2_q && !buy && (pg_q > pob_q) && (hold_x > -lim_x);

  assign cash_x   = {{2{cash_q[CashW-1]}}, cash_q};
  assign price_x  = ExtW'(price2_q);
  assign cash_sub = cash_x - price_x;
  assign cash_add = cash_x + price_x;

  // Saturate when the guard bits disagree with the result sign
  always_comb begin
    sub_sat = cash_sub[CashW-1:0];
    if (cash_sub[ExtW-1:CashW-1] != '0 && cash_sub[ExtW-1:CashW-1] != '1) begin
      sub_sat = cash_sub[ExtW-1] ? {1'b1, {(CashW-1){1'b0}}} : {1'b0, {(CashW-1){1'b1}}};
    end
    add_sat = cash_add[CashW-1:0];
    if (cash_add[ExtW-1:CashW-1] != '0 && cash_add[ExtW-1:CashW-1] != '1) begin
      add_sat = cash_add[ExtW-1] ? {1'b1, {(CashW-1){1'b0}}} : {1'b0, {(CashW-1){1'b1}}};
    end
  end

  always_comb begin
    act_d  = ACT_HOLD;
    hold_d = hold_q;
    cash_d = cash_q;
    if (buy) begin
      act_d  = ACT_BUY;
      hold_d = hold_q + 8'sd1;
      cash_d = $signed(sub_sat);
    end else if (sell) begin
      act_d  = ACT_SELL;
      hold_d = hold_q - 8'sd1;
      cash_d = $signed(add_sat);
    end
    rep_d = (act_d != ACT_HOLD) && (act_d != dir_q);
  end

  always_comb begin
    v3_d = v3_q;
    if (mv23) begin
      v3_d = 1'b1;
    end else if (m_axis_tready_i) begin
      v3_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q   <= 1'b0;
      hold_q <= '0;
      cash_q <= '0;
      dir_q  <= ACT_HOLD;
    end else begin
      v3_q <= v3_d;
      if (mv23) begin
        hold_q <= hold_d;
        cash_q <= cash_d;
        if (act_d != ACT_HOLD) begin
          dir_q <= act_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv23) begin
      rdy3_q <= rdy2_q;
      act_q  <= act_d;
      rep_q  <= rep_d;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {7'b0, rep_q, cash_q, hold_q};
  assign m_axis_tuser_o  = {act_q, rdy3_q};

  ap_warm_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !rdy3_q |-> act_q == ACT_HOLD && !rep_q)
    else $error("order issued during warm-up");

  ap_report_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && rep_q |-> act_q != ACT_HOLD)
    else $error("order report without an order");

  ap_buy_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv23 && buy |=> hold_q == $past(hold_q) + 8'sd1)
    else $error("buy did not raise the holding by one");

  ap_hold_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q != 8'sh80)
    else $error("holding left its range");

endmodule

// ===== hw/rtl/rsi_threshold_trader_core.sv =====
// Top level of the RSI threshold trader: config registers, window stage and output.
//
//  channel   | direction | transfer when            | payload
//  s_axis    | in        | tvalid & tready          | tdata: price
//  m_axis    | out       | tvalid & tready          | tuser: ready_res, action;
//            |           |                          | tdata: holding, cash, report_order
//  cfg       | in        | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
//  One price per clock while the output is not stalled; a result passes the window sums,
//  registered at its transfer edge, then the RSI products, then the decision register.
//  The difference window is a row of MAX_WINDOW cells that shift once per price after the first.
//  Reset needs no clearing pass; the window is refilled over the first n+1 prices.
//  A stalled output holds the full stages; ready ripples back to the input in the same
//  cycle, so empty stages still take new items.
module rsi_threshold_trader_core import rsi_tt_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 64,
  parameter int unsigned PRICE_BITS = 32,
  localparam int unsigned InW = ((PRICE_BITS + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  // price[PRICE_BITS-1:0], zero fill above
  input  logic [InW-1:0] s_axis_tdata_i,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  // holding[7:0], cash[55:8], report_order[56], zero fill [63:57]
  output logic [63:0]    m_axis_tdata_o,
  // ready_res[0], action[2:1]
  output logic [2:0]     m_axis_tuser_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW  = $clog2(MAX_WINDOW);
  localparam int unsigned FillW = $clog2(MAX_WINDOW + 2);
  localparam int unsigned DiffW = PRICE_BITS + 1;
  localparam int unsigned SumW  = PRICE_BITS + $clog2(MAX_WINDOW);

  logic [CfgW-1:0] win_q, oversold_q, overbought_q, limit_q;
  logic            win_clr;

  logic [PRICE_BITS-1:0] price, last_price_q, price1_q;
  logic [FillW-1:0]      fill_q, fill_d, n_eff;
  logic [SumW-1:0]       gain_q, gain_d, loss_q, loss_d;
  logic [SumW-1:0]       add_g, add_l, sub_g, sub_l;
  logic [PRICE_BITS-1:0] new_mag, old_mag;
  logic signed [DiffW-1:0] diff, oldest;
  logic [IdxW-1:0]       tail_idx;
  logic                  accept, first, full, shift, take;
  item_t                 item1_q, item1_d;

  // ---- configuration registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= WindowRst;
      oversold_q   <= OversoldRst;
      overbought_q <= OverboughtRst;
      limit_q      <= LimitRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_WINDOW:     win_q        <= cfg_wdata_i;
        REG_OVERSOLD:   oversold_q   <= cfg_wdata_i;
        REG_OVERBOUGHT: overbought_q <= cfg_wdata_i;
        REG_LIMIT:      limit_q      <= cfg_wdata_i;
        default:        win_q        <= win_q;
      endcase
    end
  end

  assign win_clr = cfg_we_i && (cfg_reg_e'(cfg_index_i) == REG_WINDOW);

  // Zero acts as one, anything past the row length as the full row
  always_comb begin
    if (win_q == '0) begin
      n_eff = FillW'(1);
    end else if (32'(win_q) > MAX_WINDOW) begin
      n_eff = FillW'(MAX_WINDOW);
    end else begin
      n_eff = FillW'(win_q);
    end
  end

  assign tail_idx = IdxW'(n_eff - FillW'(1));

  // ---- window stage ----
  assign price  = s_axis_tdata_i[PRICE_BITS-1:0];
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign first  = (fill_q == '0);
  assign full   = (fill_q > n_eff);
  assign shift  = accept && !first;

  assign diff = $signed({1'b0, price}) - $signed({1'b0, last_price_q});

  rsi_tt_chain #(
    .MAX_WINDOW (MAX_WINDOW),
    .DIFF_W     (DiffW)
  ) u_chain (
    .clk_i      (clk_i),
    .shift_i    (shift),
    .tail_idx_i (tail_idx),
    .new_diff_i (diff),
    .oldest_o   (oldest)
  );

  assign new_mag = diff[DiffW-1]   ? PRICE_BITS'(-diff)   : PRICE_BITS'(diff);
  assign old_mag = oldest[DiffW-1] ? PRICE_BITS'(-oldest) : PRICE_BITS'(oldest);

  // A positive difference counts as gain, anything else as loss
  assign add_g = (shift && diff > 0)           ? SumW'(new_mag) : '0;
  assign add_l = (shift && !(diff > 0))        ? SumW'(new_mag) : '0;
  assign sub_g = (shift && full && oldest > 0)    ? SumW'(old_mag) : '0;
  assign sub_l = (shift && full && !(oldest > 0)) ? SumW'(old_mag) : '0;

  always_comb begin
    gain_d = gain_q + add_g - sub_g;
    loss_d = loss_q + add_l - sub_l;
    fill_d = fill_q;
    if (accept) begin
      if (first) begin
        fill_d = FillW'(1);
      end else if (!full) begin
        fill_d = fill_q + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      gain_q       <= '0;
      loss_q       <= '0;
      last_price_q <= '0;
    end else if (win_clr) begin
      fill_q <= '0;
      gain_q <= '0;
      loss_q <= '0;
    end else if (accept) begin
      fill_q       <= fill_d;
      gain_q       <= gain_d;
      loss_q       <= loss_d;
      last_price_q <= price;
    end
  end

  // ---- stage 1 handshake ----
  assign s_axis_tready_o = !item1_q.valid || take;

  always_comb begin
    item1_d = item1_q;
    if (accept) begin
      item1_d.valid     = 1'b1;
      item1_d.ready_res = shift && full;
    end else if (take) begin
      item1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item1_q <= '0;
    end else begin
      item1_q <= item1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      price1_q <= price;
    end
  end

  rsi_tt_decide #(
    .PRICE_BITS (PRICE_BITS),
    .SUM_W      (SumW)
  ) u_decide (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item1_q),
    .price_i         (price1_q),
    .gain_i          (gain_q),
    .loss_i          (loss_q),
    .oversold_i      (oversold_q),
    .overbought_i    (overbought_q),
    .limit_i         (limit_q),
    .take_o          (take),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
